// ===== sv/adsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adsd_pkg
// Shared constants, tables and types of the stick dead zone and direction unit.
// ----------------------------------------------------------------------------
package adsd_pkg;

  // number formats
  localparam int ANGLE_BITS    = 16;
  localparam int MAG_FRAC_BITS = 8;

  // field widths
  localparam int AXIS_W = 9;
  localparam int CFG_W  = 8;
  localparam int MAG_W  = 16;
  localparam int HEAD_W = 16;
  localparam int DIR_W  = 4;

  // squared radius and square root
  localparam int SQ_W       = 2 * AXIS_W - 1;
  localparam int S_W        = 2 * AXIS_W;
  localparam int V_W        = S_W + 2 * MAG_FRAC_BITS;
  localparam int SQRT_STEPS = V_W / 2;
  localparam int ROOT_W     = SQRT_STEPS;
  localparam int REM_W      = ROOT_W + 3;

  // rescale divide: quotient below 128 full units
  localparam int DIV_STEPS = 7 + MAG_FRAC_BITS;
  localparam int DREM_W    = ROOT_W + 7 - DIV_STEPS;
  localparam logic [MAG_W-1:0] MAG_FULL = MAG_W'(1) << DIV_STEPS;

  // angle unit
  localparam int CORDIC_STEPS = 31;
  localparam int CORDIC_W     = 32;
  localparam int CORDIC_SCALE = 20;
  localparam logic [31:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001
  };

  // pipeline lengths in register stages
  localparam int MAG_LAT    = SQRT_STEPS + DIV_STEPS + 2;
  localparam int CORDIC_LAT = CORDIC_STEPS + 1;
  localparam int HEAD_DLY   = MAG_LAT - CORDIC_LAT;

  // direction word bits
  localparam logic [DIR_W-1:0] DIR_UP    = 4'b0001;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 4'b0010;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 4'b0100;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 4'b1000;

  // register indexes
  localparam logic [1:0] REG_DEAD_ZONE = 2'd0;
  localparam logic [1:0] REG_SPAN      = 2'd1;
  localparam logic [1:0] REG_GATE      = 2'd2;

  // sideband that travels next to the magnitude pipeline
  typedef struct packed {
    logic             centred;
    logic [DIR_W-1:0] dir;
  } side_t;

endpackage
`default_nettype wire

// ===== sv/analog_stick_deadzone_direction_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// analog_stick_deadzone_direction_unit
// Radial dead zone, rescaled magnitude, heading and 8-way direction word.
// ----------------------------------------------------------------------------
// Usage:
//   A sample transfer happens at each clock edge with start high and busy low.
//   busy stays low: the pipeline takes one sample every cycle.
//   Each result appears on out_magnitude, out_heading and out_direction_bits
//   for one cycle with out_strobe high.
//   The magnitude path sets when the result appears: input, square and sum stages,
//   the radicand load, 17 square root stages, one offset stage, 15 divide
//   stages and the output register; the 32-stage heading path is delayed
//   to line up with it.
//   The receiver cannot stall; results are never held back.
//   Registers dead_zone (0x0), span (0x4) and gate (0x8) are written over
//   the APB port; the user must write them only while no sample is in flight, the block does not enforce it.
//   Synchronous reset empties the pipeline and loads the register defaults
//   (dead_zone 60, span 68, gate 100); no result is produced until a new
//   sample transfer.
// ----------------------------------------------------------------------------
module analog_stick_deadzone_direction_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // sample channel
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [adsd_pkg::AXIS_W-1:0] in_right_axis,
  input  wire logic signed [adsd_pkg::AXIS_W-1:0] in_up_axis,
  // result channel
  output logic                                    out_strobe,
  output logic             [adsd_pkg::MAG_W-1:0]  out_magnitude,
  output logic signed      [adsd_pkg::HEAD_W-1:0] out_heading,
  output logic             [adsd_pkg::DIR_W-1:0]  out_direction_bits,
  // configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic        [3:0]                  paddr,
  input  wire logic        [31:0]                 pwdata,
  output logic             [31:0]                 prdata,
  output logic                                    pready
);

  localparam int AW  = adsd_pkg::AXIS_W;
  localparam int CW  = adsd_pkg::CFG_W;
  localparam int LAT = adsd_pkg::MAG_LAT;
  localparam int HD  = adsd_pkg::HEAD_DLY;

  // configuration registers
  logic [CW-1:0]     dead_zone_r;
  logic [CW-1:0]     span_r;
  logic [CW-1:0]     gate_r;
  logic [2*CW-1:0]   dz_sq_r;
  logic              cfg_wr;

  // front stages
  logic                             v0_r, v1_r, v2_r;
  logic signed [AW-1:0]             x0_r, y0_r, x1_r, y1_r, x2_r, y2_r;
  logic [adsd_pkg::SQ_W-1:0]        xx1_r, yy1_r;
  logic [adsd_pkg::S_W-1:0]         s2_r;
  adsd_pkg::side_t                  side2_r;
  logic signed [2*AW-1:0]           xsq, ysq;
  logic [adsd_pkg::S_W-1:0]         s_nxt;
  adsd_pkg::side_t                  side_nxt;
  logic [adsd_pkg::DIR_W-1:0]       h_dir, v_dir;
  logic [adsd_pkg::SQ_W+1:0]        yy3, xx3;

  // alignment chains
  logic                             vld_r  [0:LAT-1];
  adsd_pkg::side_t                  side_r [0:LAT-1];
  logic [adsd_pkg::HEAD_W-1:0]      hd_r   [0:HD-1];

  // unit results
  logic [adsd_pkg::MAG_W-1:0]       mag;
  logic [adsd_pkg::HEAD_W-1:0]      head;
  logic                             above_gate;
  adsd_pkg::side_t                  side_out;

  // output registers
  logic                             out_strobe_r;
  logic [adsd_pkg::MAG_W-1:0]       out_mag_r;
  logic [adsd_pkg::HEAD_W-1:0]      out_head_r;
  logic [adsd_pkg::DIR_W-1:0]       out_dir_r;

  // register write and read
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r <= 8'd60;
      span_r      <= 8'd68;
      gate_r      <= 8'd100;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        adsd_pkg::REG_DEAD_ZONE: dead_zone_r <= pwdata[CW-1:0];
        adsd_pkg::REG_SPAN:      span_r      <= pwdata[CW-1:0];
        adsd_pkg::REG_GATE:      gate_r      <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      adsd_pkg::REG_DEAD_ZONE: prdata = 32'(dead_zone_r);
      adsd_pkg::REG_SPAN:      prdata = 32'(span_r);
      adsd_pkg::REG_GATE:      prdata = 32'(gate_r);
      default:                 prdata = '0;
    endcase
  end

  // squared dead zone follows the register
  always_ff @(posedge clk) begin
    dz_sq_r <= dead_zone_r * dead_zone_r;
  end

  // never stalls
  assign busy = 1'b0;

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  // squares
  assign xsq = x0_r * x0_r;
  assign ysq = y0_r * y0_r;

  // radius sum, dead zone test and sector choice
  assign s_nxt = adsd_pkg::S_W'(xx1_r) + adsd_pkg::S_W'(yy1_r);
  assign xx3   = (adsd_pkg::SQ_W+2)'(xx1_r) + (adsd_pkg::SQ_W+2)'({xx1_r, 1'b0});
  assign yy3   = (adsd_pkg::SQ_W+2)'(yy1_r) + (adsd_pkg::SQ_W+2)'({yy1_r, 1'b0});
  assign h_dir = (x1_r > 0) ? adsd_pkg::DIR_RIGHT : adsd_pkg::DIR_LEFT;
  assign v_dir = (y1_r > 0) ? adsd_pkg::DIR_UP : adsd_pkg::DIR_DOWN;

  always_comb begin
    side_nxt.centred = (s_nxt < adsd_pkg::S_W'(dz_sq_r));
    if (yy3 < (adsd_pkg::SQ_W+2)'(xx1_r)) begin
      side_nxt.dir = h_dir;
    end else if ((adsd_pkg::SQ_W+2)'(yy1_r) > xx3) begin
      side_nxt.dir = v_dir;
    end else begin
      side_nxt.dir = h_dir | v_dir;
    end
  end

  // front payload
  always_ff @(posedge clk) begin
    x0_r    <= in_right_axis;
    y0_r    <= in_up_axis;
    x1_r    <= x0_r;
    y1_r    <= y0_r;
    xx1_r   <= xsq[adsd_pkg::SQ_W-1:0];
    yy1_r   <= ysq[adsd_pkg::SQ_W-1:0];
    x2_r    <= x1_r;
    y2_r    <= y1_r;
    s2_r    <= s_nxt;
    side2_r <= side_nxt;
  end

  // magnitude path
  adsd_mag u_mag (
    .clk       (clk),
    .s         (s2_r),
    .dead_zone (dead_zone_r),
    .span      (span_r),
    .mag       (mag)
  );

  // heading path
  adsd_cordic u_cordic (
    .clk     (clk),
    .x       (x2_r),
    .y       (y2_r),
    .heading (head)
  );

  // valid chain alongside the magnitude path
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      vld_r[0] <= v2_r;
      for (int k = 1; k < LAT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // sideband and heading alignment
  always_ff @(posedge clk) begin
    side_r[0] <= side2_r;
    for (int k = 1; k < LAT; k++) begin
      side_r[k] <= side_r[k-1];
    end
    hd_r[0] <= head;
    for (int k = 1; k < HD; k++) begin
      hd_r[k] <= hd_r[k-1];
    end
  end

  // gate test and final select
  assign side_out   = side_r[LAT-1];
  assign above_gate = ({8'b0, mag} > ((adsd_pkg::MAG_W+8)'(gate_r) << adsd_pkg::MAG_FRAC_BITS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (side_out.centred) begin
      out_mag_r  <= '0;
      out_head_r <= '0;
      out_dir_r  <= '0;
    end else begin
      out_mag_r  <= mag;
      out_head_r <= hd_r[HD-1];
      out_dir_r  <= above_gate ? side_out.dir : '0;
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_magnitude      = out_mag_r;
  assign out_heading        = out_head_r;
  assign out_direction_bits = out_dir_r;

endmodule
`default_nettype wire

// ===== sv/adsd_mag.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adsd_mag
// Pipelined square root of the squared radius, dead zone offset and rescale
// divide by span, one bit per stage, saturated at full scale.
// ----------------------------------------------------------------------------
module adsd_mag (
  input  wire logic                              clk,
  input  wire logic [adsd_pkg::S_W-1:0]          s,
  input  wire logic [adsd_pkg::CFG_W-1:0]        dead_zone,
  input  wire logic [adsd_pkg::CFG_W-1:0]        span,
  output logic      [adsd_pkg::MAG_W-1:0]        mag
);

  localparam int SQ  = adsd_pkg::SQRT_STEPS;
  localparam int DV  = adsd_pkg::DIV_STEPS;
  localparam int RW  = adsd_pkg::ROOT_W;
  localparam int MW  = adsd_pkg::REM_W;
  localparam int DW  = adsd_pkg::DREM_W;
  localparam int FB  = adsd_pkg::MAG_FRAC_BITS;

  // square root stages
  logic [adsd_pkg::V_W-1:0] sv_r [0:SQ];
  logic [MW-1:0]            sr_r [0:SQ];
  logic [RW-1:0]            rt_r [0:SQ];

  // divide stages
  logic [DW-1:0] dr_r  [0:DV];
  logic [DV-1:0] dn_r  [0:DV];
  logic [DV-1:0] dq_r  [0:DV];
  logic          sat_r [0:DV];

  // offset and saturation check on the root
  logic [RW-1:0]    dz_sh;
  logic [RW-1:0]    diff;
  logic [RW+6:0]    num;

  // load the radicand
  always_ff @(posedge clk) begin
    sv_r[0] <= {s, {(2 * FB){1'b0}}};
    sr_r[0] <= '0;
    rt_r[0] <= '0;
  end

  // one root bit per stage
  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam int P = SQ - 1 - k;
    logic [MW-1:0] rem_sh;
    logic [MW-1:0] trial;
    logic          ge;
    assign rem_sh = {sr_r[k][MW-3:0], sv_r[k][2*P+1 -: 2]};
    assign trial  = MW'({rt_r[k], 2'b01});
    assign ge     = (rem_sh >= trial);
    always_ff @(posedge clk) begin
      sv_r[k+1] <= sv_r[k];
      sr_r[k+1] <= ge ? (rem_sh - trial) : rem_sh;
      rt_r[k+1] <= {rt_r[k][RW-2:0], ge};
    end
  end

  // subtract the dead zone and check against full scale
  assign dz_sh = RW'(dead_zone) << FB;
  assign diff  = (rt_r[SQ] > dz_sh) ? (rt_r[SQ] - dz_sh) : '0;
  assign num   = {diff, 7'b0};

  always_ff @(posedge clk) begin
    sat_r[0] <= (diff >= (RW'(span) << FB));
    dr_r[0]  <= num[RW+6:DV];
    dn_r[0]  <= num[DV-1:0];
    dq_r[0]  <= '0;
  end

  // one quotient bit per stage
  for (genvar k = 0; k < DV; k++) begin : g_div
    logic [DW-1:0] rem_sh;
    logic          ge;
    assign rem_sh = {dr_r[k][DW-2:0], dn_r[k][DV-1-k]};
    assign ge     = (rem_sh >= DW'(span));
    always_ff @(posedge clk) begin
      sat_r[k+1] <= sat_r[k];
      dn_r[k+1]  <= dn_r[k];
      dr_r[k+1]  <= ge ? (rem_sh - DW'(span)) : rem_sh;
      dq_r[k+1]  <= {dq_r[k][DV-2:0], ge};
    end
  end

  // saturate at full scale
  assign mag = sat_r[DV] ? adsd_pkg::MAG_FULL : adsd_pkg::MAG_W'(dq_r[DV]);

endmodule
`default_nettype wire

// ===== sv/adsd_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adsd_cordic
// Vectoring CORDIC heading, one rotation per stage after a half turn
// pre-rotation for the left half plane.
// ----------------------------------------------------------------------------
module adsd_cordic (
  input  wire logic                               clk,
  input  wire logic signed [adsd_pkg::AXIS_W-1:0] x,
  input  wire logic signed [adsd_pkg::AXIS_W-1:0] y,
  output logic             [adsd_pkg::HEAD_W-1:0] heading
);

  localparam int N  = adsd_pkg::CORDIC_STEPS;
  localparam int CW = adsd_pkg::CORDIC_W;

  logic signed [CW-1:0] cx_r   [0:N];
  logic signed [CW-1:0] cy_r   [0:N];
  logic        [31:0]   acc_r  [0:N];
  logic                 zero_r [0:N];

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic        [31:0]   rounded;

  // scale up and fold the left half plane
  assign xs = CW'(x) <<< adsd_pkg::CORDIC_SCALE;
  assign ys = CW'(y) <<< adsd_pkg::CORDIC_SCALE;

  always_ff @(posedge clk) begin
    zero_r[0] <= (x == '0) && (y == '0);
    if (x < 0) begin
      cx_r[0]  <= -xs;
      cy_r[0]  <= -ys;
      acc_r[0] <= 32'h80000000;
    end else begin
      cx_r[0]  <= xs;
      cy_r[0]  <= ys;
      acc_r[0] <= '0;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [CW-1:0] xsh;
    logic signed [CW-1:0] ysh;
    assign xsh = cx_r[i] >>> i;
    assign ysh = cy_r[i] >>> i;
    always_ff @(posedge clk) begin
      zero_r[i+1] <= zero_r[i];
      if (cy_r[i] > 0) begin
        cx_r[i+1]  <= cx_r[i] + ysh;
        cy_r[i+1]  <= cy_r[i] - xsh;
        acc_r[i+1] <= acc_r[i] + adsd_pkg::ATAN_TAB[i];
      end else begin
        cx_r[i+1]  <= cx_r[i] - ysh;
        cy_r[i+1]  <= cy_r[i] + xsh;
        acc_r[i+1] <= acc_r[i] - adsd_pkg::ATAN_TAB[i];
      end
    end
  end

  // round to the heading width, origin reads as zero
  assign rounded = acc_r[N] + (32'd1 << (31 - adsd_pkg::ANGLE_BITS));
  assign heading = zero_r[N] ? '0
                 : adsd_pkg::HEAD_W'(rounded >> (32 - adsd_pkg::ANGLE_BITS));

endmodule
`default_nettype wire
